### sv/mer_pkg.sv
// Shared types, constants and helpers for the note-event loop recorder.
// Used by every module of the block; depends on nothing.
package mer_pkg;

    localparam int DEPTH     = 256;
    localparam int TIME_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);

    typedef logic [ADDR_W-1:0]    mer_addr_t;
    typedef logic [TIME_BITS-1:0] mer_time_t;

    localparam mer_addr_t LAST_POS = ADDR_W'(DEPTH - 1);
    localparam mer_addr_t FULL_POS = ADDR_W'(DEPTH - 2);

    localparam logic [1:0] ACT_NOTE   = 2'd0;
    localparam logic [1:0] ACT_SWITCH = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [7:0] END_MARK     = 8'h00;
    localparam logic [7:0] RELEASE_MASK = 8'b1110_1111;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] command;
        logic [7:0] tone;
        logic [7:0] velocity;
        logic       play_switch;
        logic       record_switch;
    } mer_in_t;

    typedef struct packed {
        logic [7:0] out_command;
        logic [7:0] out_tone;
        logic [7:0] out_velocity;
    } mer_out_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] tone;
        logic [7:0] velocity;
        mer_time_t  time_stamp;
    } mer_entry_t;

    typedef struct packed {
        logic       rd_en;
        mer_addr_t  rd_addr;
        logic       wr_en;
        mer_addr_t  wr_addr;
        mer_entry_t wr_data;
    } mer_mem_req_t;

    typedef struct packed {
        logic     load;
        mer_out_t data;
    } mer_out_req_t;

    function automatic mer_addr_t next_pos(input mer_addr_t p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

endpackage

### sv/mer_ram.sv
// Event store: one write port and one read port, read data registered.
// Depends on mer_pkg for depth and entry layout.
module mer_ram import mer_pkg::*; (
    input  logic         aclk,
    input  mer_mem_req_t req,
    output mer_entry_t   rd_data
);

    mer_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

### sv/mer_seq.sv
// Sequencer: record, play and tick handling around the event store.
// Depends on mer_pkg; drives the store request and the output load.
module mer_seq import mer_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  mer_in_t      s_data,
    input  logic         out_free,
    output mer_out_req_t out_req,
    output mer_mem_req_t mem_req,
    input  mer_entry_t   rd_data
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT,
        ST_ZERO,
        ST_TGT,
        ST_REC,
        ST_PAD,
        ST_MARK
    } state_t;

    state_t    state_reg, state_next;
    mer_addr_t pos_reg, pos_next;
    mer_addr_t clr_reg, clr_next;
    mer_time_t time_reg, time_next;
    mer_time_t target_reg, target_next;
    logic      recording_reg, recording_next;
    logic      playing_reg, playing_next;
    mer_in_t   item_reg, item_next;
    mer_time_t time_inc;
    logic      stop_go;

    assign s_ready  = (state_reg == ST_IDLE);
    assign time_inc = time_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        clr_next       = clr_reg;
        time_next      = time_reg;
        target_next    = target_reg;
        recording_next = recording_reg;
        playing_next   = playing_reg;
        item_next      = item_reg;
        stop_go        = 1'b0;
        mem_req        = '0;
        out_req.load   = 1'b0;
        out_req.data.out_command  = rd_data.command;
        out_req.data.out_tone     = rd_data.tone;
        out_req.data.out_velocity = rd_data.velocity;

        case (state_reg)
            ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == LAST_POS) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    case (s_data.action)
                        ACT_NOTE: begin
                            if (recording_reg) begin
                                if (pos_reg == FULL_POS) begin
                                    stop_go = 1'b1;
                                end else begin
                                    mem_req.wr_en            = 1'b1;
                                    mem_req.wr_addr          = pos_reg;
                                    mem_req.wr_data.command  = s_data.command;
                                    mem_req.wr_data.tone     = s_data.tone;
                                    mem_req.wr_data.velocity = s_data.velocity;
                                    mem_req.wr_data.time_stamp =
                                        (pos_reg == '0) ? '0 : time_reg;
                                    if (pos_reg == '0) begin
                                        time_next = '0;
                                    end
                                    pos_next = next_pos(pos_reg);
                                end
                            end
                        end
                        ACT_SWITCH: begin
                            state_next = ST_REC;
                            if (s_data.play_switch && !playing_reg) begin
                                playing_next    = 1'b1;
                                pos_next        = '0;
                                time_next       = '0;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                state_next      = ST_EMIT;
                            end else if (!s_data.play_switch && playing_reg) begin
                                playing_next = 1'b0;
                                if (pos_reg[0]) begin
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr = pos_reg;
                                    state_next      = ST_EMIT;
                                end
                            end
                        end
                        ACT_TICK: begin
                            time_next = time_inc;
                            if (playing_reg && time_inc == target_reg) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pos_reg;
                                state_next      = ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT: begin
                if (rd_data.command == END_MARK) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    state_next      = ST_ZERO;
                end else if (out_free) begin
                    out_req.load    = 1'b1;
                    pos_next        = next_pos(pos_reg);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = next_pos(pos_reg);
                    state_next      = ST_TGT;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    out_req.load    = 1'b1;
                    pos_next        = next_pos('0);
                    time_next       = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = next_pos('0);
                    state_next      = ST_TGT;
                end
            end
            ST_TGT: begin
                target_next = rd_data.time_stamp;
                state_next  = (item_reg.action == ACT_SWITCH) ? ST_REC : ST_IDLE;
            end
            ST_REC: begin
                state_next = ST_IDLE;
                if (item_reg.record_switch && !recording_reg) begin
                    recording_next = 1'b1;
                    pos_next       = '0;
                    time_next      = '0;
                end else if (!item_reg.record_switch && recording_reg) begin
                    stop_go = 1'b1;
                end
            end
            ST_PAD: begin
                mem_req.wr_en              = 1'b1;
                mem_req.wr_addr            = pos_reg;
                mem_req.wr_data.command    = rd_data.command & RELEASE_MASK;
                mem_req.wr_data.tone       = rd_data.tone;
                mem_req.wr_data.velocity   = item_reg.velocity;
                mem_req.wr_data.time_stamp = time_reg;
                pos_next                   = next_pos(pos_reg);
                state_next                 = ST_MARK;
            end
            ST_MARK: begin
                mem_req.wr_en              = 1'b1;
                mem_req.wr_addr            = pos_reg;
                mem_req.wr_data.time_stamp = time_reg;
                recording_next             = 1'b0;
                state_next                 = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        // close an open press, then write the end marker
        if (stop_go) begin
            if (pos_reg[0]) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pos_reg - 1'b1;
                state_next      = ST_PAD;
            end else begin
                mem_req.wr_en              = 1'b1;
                mem_req.wr_addr            = pos_reg;
                mem_req.wr_data            = '0;
                mem_req.wr_data.time_stamp = time_reg;
                recording_next             = 1'b0;
                state_next                 = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            clr_reg       <= '0;
            time_reg      <= '0;
            target_reg    <= '0;
            recording_reg <= 1'b0;
            playing_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            clr_reg       <= clr_next;
            time_reg      <= time_next;
            target_reg    <= target_next;
            recording_reg <= recording_next;
            playing_reg   <= playing_next;
        end
        item_reg <= item_next;
    end

endmodule

### sv/midi_event_loop_recorder_core.sv
// Top level of the note-event loop recorder: sequencer, event store, output register.
// Depends on mer_pkg, mer_ram and mer_seq.
//
// After reset the block sweeps all DEPTH (256) entries of the event store to zero, one
// entry a cycle, with s_ready low. A note word, a tick that emits nothing and an ignored
// action stay in ST_IDLE. A word that emits an entry goes through ST_EMIT (and ST_ZERO
// at the end marker) and ST_TGT, as store reads are registered: the entry is read, then
// the time of the next entry. A switch word also goes to ST_REC for the record decision;
// stopping a recording with an open press adds ST_PAD and ST_MARK to pad a release and
// write the end marker. A result waits in the output register while new words are taken;
// a word that must emit while that register is still full holds until it drains.
module midi_event_loop_recorder_core import mer_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mer_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output mer_out_t m_data
);

    mer_mem_req_t mem_req;
    mer_entry_t   rd_data;
    mer_out_req_t out_req;
    logic         m_valid_reg, m_valid_next;
    mer_out_t     m_data_reg;
    logic         out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    mer_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .out_req  (out_req),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    mer_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_req.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (out_req.load) begin
            m_data_reg <= out_req.data;
        end
    end

endmodule

### sim/testbench.sv
// Self-checking bench for the note-event loop recorder: queued words, a checker of played notes.
// Records takes, plays them back by ticks, and compares every played note with its own model.
// Depends on mer_pkg and midi_event_loop_recorder_core.
module testbench import mer_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 64;
    localparam int         STIM_WORDS  = 730;

    typedef struct {
        mer_in_t     word;
        bit          hold;
        int unsigned idle_after;
    } pending_word_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    mer_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mer_out_t m_data;

    pending_word_t stim_q[$];
    pending_word_t front;
    mer_out_t      due_notes[$];
    mer_out_t      want;
    bit            calm;
    int unsigned   gap_left;
    int unsigned   sink_wait;
    int unsigned   sink_draw;
    bit            sink_calm;
    int            error_count;
    int            cycle_count;

    logic [7:0] take_cmd  [DEPTH];
    logic [7:0] take_tone [DEPTH];
    logic [7:0] take_vel  [DEPTH];
    mer_time_t  take_time [DEPTH];
    mer_addr_t  cue_pos;
    mer_time_t  clock_now;
    mer_time_t  cue_time;
    bit         rec_on;
    bit         play_on;

    midi_event_loop_recorder_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic mer_addr_t bump(input mer_addr_t p);
        return (p == mer_addr_t'(DEPTH - 1)) ? '0 : mer_addr_t'(p + 1'b1);
    endfunction

    function automatic void store_slot(input mer_addr_t p, input logic [7:0] c,
                                       input logic [7:0] t, input logic [7:0] v,
                                       input mer_time_t tm);
        take_cmd[p]  = c;
        take_tone[p] = t;
        take_vel[p]  = v;
        take_time[p] = tm;
    endfunction

    // Play the slot under the cue; an end marker rewinds to the first slot.
    function automatic void sound_slot();
        mer_out_t note;
        if (take_cmd[cue_pos] == END_MARK) begin
            note.out_command  = take_cmd[0];
            note.out_tone     = take_tone[0];
            note.out_velocity = take_vel[0];
            cue_pos   = bump('0);
            clock_now = '0;
        end else begin
            note.out_command  = take_cmd[cue_pos];
            note.out_tone     = take_tone[cue_pos];
            note.out_velocity = take_vel[cue_pos];
            cue_pos = bump(cue_pos);
        end
        cue_time = take_time[cue_pos];
        due_notes.push_back(note);
    endfunction

    // Close a take: pad a release for a dangling press, then mark the end.
    function automatic void close_take(input logic [7:0] vel);
        mer_addr_t prev;
        if (cue_pos[0]) begin
            prev = mer_addr_t'(cue_pos - 1'b1);
            store_slot(cue_pos, take_cmd[prev] & RELEASE_MASK, take_tone[prev], vel, clock_now);
            cue_pos = bump(cue_pos);
        end
        store_slot(cue_pos, END_MARK, 8'h00, 8'h00, clock_now);
        rec_on = 1'b0;
    endfunction

    function automatic void advance_looper(input mer_in_t w);
        case (w.action)
            ACT_NOTE: begin
                if (rec_on && cue_pos == FULL_POS) close_take(w.velocity);
                if (rec_on) begin
                    if (cue_pos == '0) clock_now = '0;
                    store_slot(cue_pos, w.command, w.tone, w.velocity, clock_now);
                    cue_pos = bump(cue_pos);
                end
            end
            ACT_SWITCH: begin
                if (w.play_switch) begin
                    if (!play_on) begin
                        play_on = 1'b1;
                        cue_pos = '0;
                        sound_slot();
                        clock_now = '0;
                    end
                end else if (play_on) begin
                    play_on = 1'b0;
                    if (cue_pos[0]) sound_slot();
                end
                if (w.record_switch) begin
                    if (!rec_on) begin
                        rec_on    = 1'b1;
                        cue_pos   = '0;
                        clock_now = '0;
                    end
                end else if (rec_on) begin
                    close_take(w.velocity);
                end
            end
            ACT_TICK: begin
                clock_now = clock_now + 1'b1;
                if (play_on && clock_now == cue_time) sound_slot();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_word(input logic [1:0] act, input logic [7:0] cmd,
                              input logic [7:0] tn, input logic [7:0] vel,
                              input bit play, input bit rec, input bit hold);
        pending_word_t p;
        p.word.action        = act;
        p.word.command       = cmd;
        p.word.tone          = tn;
        p.word.velocity      = vel;
        p.word.play_switch   = play;
        p.word.record_switch = rec;
        p.hold               = hold;
        p.idle_after         = calm ? 0 : $urandom_range(0, 17);
        stim_q.push_back(p);
    endtask

    task automatic queue_tick();
        queue_word(ACT_TICK, rnd8(), rnd8(), rnd8(), 1'($urandom), 1'($urandom), 1'b0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) advance_looper(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (stim_q.size() != 0 &&
                             (!stim_q[0].hold || due_notes.size() == 0)) begin
                    front    = stim_q.pop_front();
                    s_data   <= front.word;
                    s_valid  <= 1'b1;
                    gap_left <= front.idle_after;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
            sink_calm <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (due_notes.size() == 0) begin
                report_error($sformatf("unexpected note %h %h %h", m_data.out_command,
                                       m_data.out_tone, m_data.out_velocity));
            end else begin
                want = due_notes.pop_front();
                if (m_data.out_command !== want.out_command)
                    report_error($sformatf("out_command %h, want %h",
                                           m_data.out_command, want.out_command));
                if (m_data.out_tone !== want.out_tone)
                    report_error($sformatf("out_tone %h, want %h",
                                           m_data.out_tone, want.out_tone));
                if (m_data.out_velocity !== want.out_velocity)
                    report_error($sformatf("out_velocity %h, want %h",
                                           m_data.out_velocity, want.out_velocity));
            end
            sink_draw = sink_calm ? 0 : $urandom_range(0, 17);
            sink_wait <= sink_draw;
            m_ready   <= (sink_draw == 0);
            if ($urandom_range(0, 24) == 0) sink_calm <= !sink_calm;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= (sink_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned n;
        int unsigned gaps;
        int unsigned span;
        int unsigned laps;
        bit          filled;

        error_count = 0;
        filled      = 1'b0;
        take_cmd    = '{default: '0};
        take_tone   = '{default: '0};
        take_vel    = '{default: '0};
        take_time   = '{default: '0};
        cue_pos     = '0;
        clock_now   = '0;
        cue_time    = '0;
        rec_on      = 1'b0;
        play_on     = 1'b0;

        // directed: idle words, empty store playback, a short take with a padded release
        calm = 1'b0;
        queue_word(ACT_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_NOTE,   8'h90, 8'h3C, 8'h64, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        queue_word(ACT_NOTE,   8'h90, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_NOTE,   8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0);
        queue_word(ACT_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_NOTE,   8'h9F, 8'h40, 8'h7F, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h55, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        repeat (6) queue_word(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_word(ACT_SWITCH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        queue_word(ACT_NOTE,   END_MARK, 8'h80, 8'h01, 1'b1, 1'b1, 1'b0);
        queue_word(ACT_SWITCH, 8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, 1'b0);

        while (stim_q.size() < STIM_WORDS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (!filled && stim_q.size() > 300) begin
                // fill the store until the full check closes the take
                filled = 1'b1;
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b0, 1'b1, 1'b1);
                repeat (DEPTH) begin
                    if ($urandom_range(0, 7) == 0) queue_tick();
                    queue_word(ACT_NOTE, rnd8() | 8'h80, rnd8(), rnd8(),
                               1'($urandom), 1'($urandom), 1'b0);
                end
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b1, 1'b0, 1'b0);
                repeat (24) queue_tick();
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b0, 1'b0, 1'b0);
            end else if ($urandom_range(0, 9) < 7) begin
                // record a take, then loop it a few times
                n    = $urandom_range(1, 12);
                span = 0;
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b0, 1'b1,
                           $urandom_range(0, 3) == 0);
                repeat (n) begin
                    queue_word(ACT_NOTE,
                               ($urandom_range(0, 23) == 0) ? END_MARK : rnd8(),
                               rnd8(), rnd8(), 1'($urandom), 1'($urandom), 1'b0);
                    gaps = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
                    repeat (gaps) queue_tick();
                    span += gaps;
                end
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b0, 1'b0, 1'b0);
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b1, 1'b0, 1'b0);
                laps = (span + 1) * $urandom_range(1, 3) + $urandom_range(0, 2);
                repeat (laps) queue_tick();
                queue_word(ACT_SWITCH, rnd8(), rnd8(), rnd8(), 1'b0, 1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 8))
                    queue_word(2'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8(),
                               1'($urandom), 1'($urandom), 1'b0);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge aclk);
        while (due_notes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (due_notes.size() != 0)
            report_error($sformatf("%0d notes never played", due_notes.size()));

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
